// ===== src/alm_pkg.sv =====
package alm_pkg;

  // fixed field widths
  localparam int FUNC_W    = 3;
  localparam int RAW_W     = 32;
  localparam int IDX_W     = 14;
  localparam int PCM_W     = 16;
  localparam int PCM_SHIFT = 16;
  localparam int LEVEL_W   = 16;
  localparam int TOTAL_W   = 32;
  localparam int SQ_W      = 31;   // 32768^2 needs 31 bits
  localparam int MEAN_W    = 32;   // radicand width of the root stage
  localparam int ROOT_W    = 16;   // root steps, two radicand bits each

  // stream packing
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 104;

  // function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_SAMPLE    = 3'd0,
    FN_ACTIVE    = 3'd1,
    FN_CAP_START = 3'd2,
    FN_CAP_CLEAR = 3'd3,
    FN_CAP_READ  = 3'd4
  } func_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACC,
    ST_CALC,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic accum;
    logic finish;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sample_go;
    logic batch_end;
    logic calc_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/audio_level_meter_with_capture_top.sv =====
// Channel | Dir | Beat                 | Payload
// s_*     | in  | one command/sample   | tuser func, tlast batch_last, tdata word/flag/index
// m_*     | out | one result per input | tlast batch_done, tdata levels and capture status
//
// Commands and ignored samples go from accept through the execute state to the
// output register; a measured sample also passes the accumulate state. A batch
// close runs the bit-serial divider over SUM_W = 30 + clog2(BATCH_MAX+1) quotient
// bits, followed by the bit-serial square root.
// rst is synchronous, active high; the record store is not cleared.
// The next beat is taken while a finished result waits on m_tready.
module audio_level_meter_with_capture_top
  import alm_pkg::*;
#(
  parameter int RECORD_DEPTH = 16384,
  parameter int BATCH_MAX    = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [31:0] raw_word, [32] active_flag, [46:33] capture_index, [47] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] func
  input  logic [FUNC_W-1:0]     s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] accepted, [16:1] pcm_sample, [32:17] rms_level, [48:33] peak_level,
  // [80:49] sample_total, [81] capturing, [82] capture_ready,
  // [98:83] capture_data, [103:99] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  cmd_t cmd;
  sts_t sts;

  alm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  alm_dp #(
    .RECORD_DEPTH (RECORD_DEPTH),
    .BATCH_MAX    (BATCH_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== src/alm_ram.sv =====
module alm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/alm_root.sv =====
module alm_root
  import alm_pkg::*;
#(
  parameter int SUM_W = 42,
  parameter int CNT_W = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   sum_in,
  input  logic [CNT_W-1:0]   count_in,
  output logic               done,
  output logic [LEVEL_W-1:0] rms
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic              phase;      // 0 divide, 1 square root
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W-1:0]  drem;
  logic [MEAN_W-1:0] rad;
  logic [ROOT_W+1:0] srem;
  logic [ROOT_W-1:0] root;

  logic [CNT_W:0]    drem_sh;
  logic              qbit;
  logic [CNT_W:0]    drem_sub;
  logic [SUM_W-1:0]  quo_next;
  logic [ROOT_W+3:0] srem_sh;
  logic [ROOT_W+3:0] trial;
  logic              rbit;
  logic [ROOT_W+3:0] srem_sub;
  logic [ROOT_W-1:0] root_next;

  // one restoring divide bit per cycle
  always_comb begin
    drem_sh  = {drem, quo[SUM_W-1]};
    qbit     = (drem_sh >= {1'b0, dvs});
    drem_sub = drem_sh - {1'b0, dvs};
    quo_next = {quo[SUM_W-2:0], qbit};
  end

  // one root bit per cycle
  always_comb begin
    srem_sh   = {srem, rad[MEAN_W-1 -: 2]};
    trial     = {2'b00, root, 2'b01};
    rbit      = (srem_sh >= trial);
    srem_sub  = srem_sh - trial;
    root_next = {root[ROOT_W-2:0], rbit};
  end

  // sequencing: divide phase, then square root phase
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        step  <= STEP_W'(SUM_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          if (!phase) begin
            phase <= 1'b1;
            step  <= STEP_W'(ROOT_W - 1);
          end else begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= sum_in;
      dvs  <= count_in;
      drem <= '0;
    end else if (busy && !phase) begin
      quo  <= quo_next;
      drem <= qbit ? drem_sub[CNT_W-1:0] : drem_sh[CNT_W-1:0];
      if (step == '0) begin
        rad  <= MEAN_W'(quo_next);
        srem <= '0;
        root <= '0;
      end
    end else if (busy && phase) begin
      rad  <= {rad[MEAN_W-3:0], 2'b00};
      srem <= rbit ? srem_sub[ROOT_W+1:0] : srem_sh[ROOT_W+1:0];
      root <= root_next;
      if (step == '0) begin
        rms <= root_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("level unit started while busy");
`endif

endmodule

// ===== src/alm_dp.sv =====
module alm_dp
  import alm_pkg::*;
#(
  parameter int RECORD_DEPTH = 16384,
  parameter int BATCH_MAX    = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [FUNC_W-1:0]     s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int CNT_W  = $clog2(BATCH_MAX + 1);
  localparam int SUM_W  = SQ_W - 1 + CNT_W;
  localparam int PTR_W  = $clog2(RECORD_DEPTH + 1);
  localparam int ADDR_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;

  // input beat
  logic [FUNC_W-1:0] func_r;
  logic [PCM_W-1:0]  pcm_r;
  logic              last_r;
  logic              act_r;
  logic [IDX_W-1:0]  idx_r;

  // architectural state
  logic               measuring;
  logic [LEVEL_W-1:0] batch_peak;
  logic [SUM_W-1:0]   batch_sum;
  logic [CNT_W-1:0]   batch_count;
  logic [LEVEL_W-1:0] rms_hold;
  logic [LEVEL_W-1:0] peak_hold;
  logic [TOTAL_W-1:0] total_count;
  logic               cap_active;
  logic               cap_done;
  logic [PTR_W-1:0]   cap_ptr;

  // per-item results
  logic              acc_r;
  logic              done_r;
  logic [SQ_W-1:0]   sq;

  logic [PCM_W-1:0]   mag;
  logic [2*PCM_W-1:0] sq_full;
  logic [CNT_W-1:0]   cnt_inc;
  logic [PTR_W-1:0]   ptr_inc;
  logic [SUM_W-1:0]   sum_inc;
  logic               cap_write;
  logic               unit_start;
  logic               unit_done;
  logic [LEVEL_W-1:0] unit_rms;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [PCM_W-1:0]   ram_rdata;
  logic               read_hit;

  // magnitude and square of the held sample
  always_comb begin
    mag     = pcm_r[PCM_W-1] ? (~pcm_r + PCM_W'(1)) : pcm_r;
    sq_full = (2*PCM_W)'(mag) * (2*PCM_W)'(mag);
  end

  // accumulate-step values
  always_comb begin
    cnt_inc    = batch_count + CNT_W'(1);
    ptr_inc    = cap_ptr + PTR_W'(1);
    sum_inc    = batch_sum + SUM_W'(sq);
    cap_write  = cap_active && (32'(cap_ptr) < 32'(RECORD_DEPTH));
    unit_start = cmd.accum && sts.batch_end;
  end

  // status to controller
  always_comb begin
    sts.sample_go = (func_r == FN_SAMPLE) && measuring;
    sts.batch_end = last_r || (32'(cnt_inc) >= 32'(BATCH_MAX));
    sts.calc_done = unit_done;
    sts.out_free  = !m_tvalid || m_tready;
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= s_tuser;
      pcm_r  <= s_tdata[PCM_SHIFT +: PCM_W];
      act_r  <= s_tdata[RAW_W];
      idx_r  <= s_tdata[RAW_W+1 +: IDX_W];
      last_r <= s_tlast;
    end
  end

  // square register between multiplier and accumulator
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      sq <= sq_full[SQ_W-1:0];
    end
  end

  // state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring   <= 1'b0;
      batch_peak  <= '0;
      batch_sum   <= '0;
      batch_count <= '0;
      rms_hold    <= '0;
      peak_hold   <= '0;
      total_count <= '0;
      cap_active  <= 1'b0;
      cap_done    <= 1'b0;
      cap_ptr     <= '0;
      acc_r       <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (cmd.exec) begin
        done_r <= 1'b0;
        case (func_r)
          FN_SAMPLE: begin
            acc_r <= measuring;
          end
          FN_ACTIVE: begin
            acc_r <= 1'b1;
            if (act_r != measuring) begin
              measuring <= act_r;
              if (!act_r) begin
                rms_hold    <= '0;
                peak_hold   <= '0;
                batch_peak  <= '0;
                batch_sum   <= '0;
                batch_count <= '0;
              end
            end
          end
          FN_CAP_START: begin
            acc_r <= !cap_active;
            if (!cap_active) begin
              cap_ptr    <= '0;
              cap_done   <= 1'b0;
              cap_active <= 1'b1;
              measuring  <= 1'b1;
            end
          end
          FN_CAP_CLEAR: begin
            acc_r    <= 1'b1;
            cap_done <= 1'b0;
            cap_ptr  <= '0;
          end
          FN_CAP_READ: begin
            acc_r <= cap_done && (32'(idx_r) < 32'(RECORD_DEPTH));
          end
          default: begin
            acc_r <= 1'b0;
          end
        endcase
      end

      // sample enters the batch and, if armed, the record
      if (cmd.accum) begin
        if (cap_write) begin
          cap_ptr <= ptr_inc;
          if (32'(ptr_inc) >= 32'(RECORD_DEPTH)) begin
            cap_active <= 1'b0;
            cap_done   <= 1'b1;
          end
        end
        if (mag > batch_peak) begin
          batch_peak <= mag;
        end
        batch_sum   <= sum_inc;
        batch_count <= cnt_inc;
        total_count <= total_count + TOTAL_W'(1);
      end

      // batch close: latch levels, open a new batch
      if (cmd.finish) begin
        rms_hold    <= unit_rms;
        peak_hold   <= batch_peak;
        batch_peak  <= '0;
        batch_sum   <= '0;
        batch_count <= '0;
        done_r      <= 1'b1;
      end
    end
  end

  // divide and square root
  alm_root #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (unit_start),
    .sum_in   (sum_inc),
    .count_in (cnt_inc),
    .done     (unit_done),
    .rms      (unit_rms)
  );

  // record store: written at the pointer, read at the requested index
  always_comb begin
    ram_we   = cmd.accum && cap_write;
    ram_addr = ram_we ? cap_ptr[ADDR_W-1:0] : ADDR_W'(idx_r);
    read_hit = acc_r && (func_r == FN_CAP_READ);
  end

  alm_ram #(
    .WIDTH (PCM_W),
    .DEPTH (RECORD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pcm_r),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {5'b0,
                  read_hit ? ram_rdata : PCM_W'(0),
                  cap_done,
                  cap_active,
                  total_count,
                  peak_hold,
                  rms_hold,
                  (func_r == FN_SAMPLE) ? pcm_r : PCM_W'(0),
                  acc_r};
      m_tlast <= done_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_cap_flags: assert property (@(posedge clk) disable iff (rst) !(cap_active && cap_done))
    else $error("capture armed and ready at once");
  a_store_range: assert property (@(posedge clk) disable iff (rst)
      ram_we |-> (32'(cap_ptr) < 32'(RECORD_DEPTH)))
    else $error("record write beyond depth");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      cmd.load_out |-> (32'(batch_count) < 32'(BATCH_MAX)))
    else $error("batch count left at or above the batch limit");
`endif

endmodule

// ===== src/alm_ctrl.sv =====
module alm_ctrl
  import alm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: state_next = sts.sample_go ? ST_ACC : ST_OUT;
      ST_ACC:  state_next = sts.batch_end ? ST_CALC : ST_OUT;
      ST_CALC: if (sts.calc_done) state_next = ST_OUT;
      ST_OUT:  if (sts.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_EXEC: cmd.exec     = 1'b1;
      ST_ACC:  cmd.accum    = 1'b1;
      ST_CALC: cmd.finish   = sts.calc_done;
      ST_OUT:  cmd.load_out = sts.out_free;
      default: cmd          = '0;
    endcase
  end

endmodule
